// ===== sv/ordered_set_successor_search_core_assert.svh =====
// assertion macros for the ordered set successor search core
`ifndef ORDERED_SET_SUCCESSOR_SEARCH_CORE_ASSERT_SVH
`define ORDERED_SET_SUCCESSOR_SEARCH_CORE_ASSERT_SVH

// checked only while out of reset
`define OSS_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// checked on every edge, reset included
`define OSS_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) prop) else $error(msg);

`endif

// ===== sv/oss_pkg.sv =====
// shared types, constants and helper functions of the successor search core
package oss_pkg;

    localparam int KEY_BITS    = 16;
    localparam int WORD_BITS   = 6;
    localparam int WORD_W      = 1 << WORD_BITS;
    localparam int LEAF_ADDR_W = KEY_BITS - WORD_BITS;
    localparam int SUM_ADDR_W  = LEAF_ADDR_W - WORD_BITS;
    localparam int LEAF_DEPTH  = 1 << LEAF_ADDR_W;
    localparam int SUM_DEPTH   = 1 << SUM_ADDR_W;
    localparam int ANS_W       = KEY_BITS + 1;

    typedef enum logic [1:0] {
        OP_INSERT = 2'd0,
        OP_NEXT   = 2'd1,
        OP_LOOKUP = 2'd2,
        OP_RSVD   = 2'd3
    } opcode_t;

    typedef struct packed {
        opcode_t               opcode;
        logic [KEY_BITS-1:0]   key;
    } in_item_t;

    typedef struct packed {
        logic [ANS_W-1:0] answer;
        logic             present;
    } out_item_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_INSERT,
        ST_LOOKUP,
        ST_LEAF,
        ST_TOP,
        ST_FETCH,
        ST_REPLY
    } state_t;

    typedef enum logic [2:0] {
        RES_ZERO,
        RES_PRESENT,
        RES_OWN,
        RES_FETCH,
        RES_NONE
    } res_sel_t;

    typedef struct packed {
        logic     clr_step;
        logic     accept;
        logic     ins_write;
        logic     fetch_sum;
        logic     save_top;
        logic     fetch_top;
        logic     res_load;
        res_sel_t res_sel;
    } dp_cmd_t;

    typedef struct packed {
        logic clr_done;
        logic own_hit;
        logic last_word;
        logic sum_hit;
        logic top_hit;
    } dp_status_t;

    // index of the lowest set bit, zero for an all-zero word
    function automatic logic [WORD_BITS-1:0] low_bit(input logic [WORD_W-1:0] v);
        logic [WORD_BITS-1:0] idx;
        idx = '0;
        for (int i = WORD_W - 1; i >= 0; i--) begin
            if (v[i]) begin
                idx = WORD_BITS'(i);
            end
        end
        return idx;
    endfunction

    // ones from bit position pos upward
    function automatic logic [WORD_W-1:0] from_mask(input logic [WORD_BITS-1:0] pos);
        return {WORD_W{1'b1}} << pos;
    endfunction

endpackage

// ===== sv/oss_ctrl.sv =====
// controller state machine of the successor search core
module oss_ctrl
    import oss_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    input  opcode_t    opcode,
    input  logic       out_free,
    input  dp_status_t status,
    output logic       s_ready,
    output logic       out_load,
    output dp_cmd_t    cmd
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_CLEAR;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        cmd.res_sel = RES_ZERO;
        s_ready    = 1'b0;
        out_load   = 1'b0;
        unique case (state_reg)
            ST_CLEAR: begin
                cmd.clr_step = 1'b1;
                if (status.clr_done) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.accept = 1'b1;
                    unique case (opcode)
                        OP_INSERT: state_next = ST_INSERT;
                        OP_NEXT:   state_next = ST_LEAF;
                        OP_LOOKUP: state_next = ST_LOOKUP;
                        default: begin
                            cmd.res_load = 1'b1;
                            cmd.res_sel  = RES_ZERO;
                            state_next   = ST_REPLY;
                        end
                    endcase
                end
            end
            ST_INSERT: begin
                cmd.ins_write = 1'b1;
                cmd.res_load  = 1'b1;
                cmd.res_sel   = RES_ZERO;
                state_next    = ST_REPLY;
            end
            ST_LOOKUP: begin
                cmd.res_load = 1'b1;
                cmd.res_sel  = RES_PRESENT;
                state_next   = ST_REPLY;
            end
            ST_LEAF: begin
                if (status.own_hit) begin
                    cmd.res_load = 1'b1;
                    cmd.res_sel  = RES_OWN;
                    state_next   = ST_REPLY;
                end else if (status.last_word) begin
                    cmd.res_load = 1'b1;
                    cmd.res_sel  = RES_NONE;
                    state_next   = ST_REPLY;
                end else if (status.sum_hit) begin
                    cmd.fetch_sum = 1'b1;
                    state_next    = ST_FETCH;
                end else if (status.top_hit) begin
                    cmd.save_top = 1'b1;
                    state_next   = ST_TOP;
                end else begin
                    cmd.res_load = 1'b1;
                    cmd.res_sel  = RES_NONE;
                    state_next   = ST_REPLY;
                end
            end
            ST_TOP: begin
                cmd.fetch_top = 1'b1;
                state_next    = ST_FETCH;
            end
            ST_FETCH: begin
                cmd.res_load = 1'b1;
                cmd.res_sel  = RES_FETCH;
                state_next   = ST_REPLY;
            end
            ST_REPLY: begin
                if (out_free) begin
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_CLEAR;
            end
        endcase
    end

endmodule

// ===== sv/oss_dp.sv =====
// datapath of the successor search core: leaf memory, summary and top bitmaps
module oss_dp
    import oss_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  dp_cmd_t    cmd,
    input  in_item_t   in_item,
    output dp_status_t status,
    output out_item_t  result
);

    logic [WORD_W-1:0]      leaf_mem [LEAF_DEPTH];
    logic [WORD_W-1:0]      leaf_q_reg;
    logic [LEAF_ADDR_W-1:0] clr_cnt_reg;
    logic [KEY_BITS-1:0]    key_reg;
    logic [LEAF_ADDR_W-1:0] word_reg;
    logic [SUM_ADDR_W-1:0]  sum_sel_reg;
    logic [WORD_W-1:0]      sum_reg [SUM_DEPTH];
    logic [SUM_DEPTH-1:0]   top_reg;
    out_item_t              result_reg;

    logic [LEAF_ADDR_W-1:0] in_word;
    logic [WORD_W-1:0]      own_bits;
    logic [LEAF_ADDR_W-1:0] next_word;
    logic [SUM_ADDR_W-1:0]  sum_addr;
    logic [WORD_W-1:0]      sum_word;
    logic [WORD_W-1:0]      sum_bits;
    logic [WORD_BITS-1:0]   sum_low;
    logic [SUM_ADDR_W:0]    top_pos;
    logic [SUM_DEPTH-1:0]   top_bits;
    logic [WORD_BITS-1:0]   top_low;
    logic                   rd_en;
    logic [LEAF_ADDR_W-1:0] rd_addr;
    logic                   wr_en;
    logic [LEAF_ADDR_W-1:0] wr_addr;
    logic [WORD_W-1:0]      wr_data;
    out_item_t              result_next;

    assign in_word   = in_item.key[KEY_BITS-1:WORD_BITS];
    assign own_bits  = leaf_q_reg & from_mask(key_reg[WORD_BITS-1:0]);
    assign next_word = word_reg + 1'b1;

    // summary word: the one holding the word after the key's word, or the one picked from the top level
    assign sum_addr = cmd.fetch_top ? sum_sel_reg : next_word[LEAF_ADDR_W-1:WORD_BITS];
    assign sum_word = sum_reg[sum_addr];
    assign sum_bits = sum_word & from_mask(next_word[WORD_BITS-1:0]);
    assign sum_low  = low_bit(cmd.fetch_top ? sum_word : sum_bits);

    assign top_pos  = {1'b0, next_word[LEAF_ADDR_W-1:WORD_BITS]} + 1'b1;
    assign top_bits = top_pos[SUM_ADDR_W] ? '0 : (top_reg & ({SUM_DEPTH{1'b1}} << top_pos[SUM_ADDR_W-1:0]));
    assign top_low  = low_bit(WORD_W'(top_bits));

    always_comb begin
        rd_en   = cmd.accept | cmd.fetch_sum | cmd.fetch_top;
        rd_addr = in_word;
        if (cmd.fetch_sum) begin
            rd_addr = {next_word[LEAF_ADDR_W-1:WORD_BITS], sum_low};
        end else if (cmd.fetch_top) begin
            rd_addr = {sum_sel_reg, sum_low};
        end
        wr_en   = cmd.clr_step | cmd.ins_write;
        wr_addr = cmd.clr_step ? clr_cnt_reg : word_reg;
        wr_data = cmd.clr_step ? '0
                               : (leaf_q_reg | (WORD_W'(1) << key_reg[WORD_BITS-1:0]));
    end

    // result selection
    always_comb begin
        result_next = '0;
        case (cmd.res_sel)
            RES_PRESENT: result_next.present = leaf_q_reg[key_reg[WORD_BITS-1:0]];
            RES_OWN:     result_next.answer  = {1'b0, word_reg, low_bit(own_bits)};
            RES_FETCH:   result_next.answer  = {1'b0, word_reg, low_bit(leaf_q_reg)};
            RES_NONE:    result_next.answer  = {1'b1, {KEY_BITS{1'b0}}};
            default:     result_next         = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            leaf_mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            leaf_q_reg <= leaf_mem[rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_cnt_reg <= '0;
            top_reg     <= '0;
            for (int i = 0; i < SUM_DEPTH; i++) begin
                sum_reg[i] <= '0;
            end
        end else begin
            if (cmd.clr_step) begin
                clr_cnt_reg <= clr_cnt_reg + 1'b1;
            end
            if (cmd.accept && in_item.opcode == OP_INSERT) begin
                sum_reg[in_word[LEAF_ADDR_W-1:WORD_BITS]][in_word[WORD_BITS-1:0]] <= 1'b1;
                top_reg[in_word[LEAF_ADDR_W-1:WORD_BITS]] <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            key_reg  <= in_item.key;
            word_reg <= in_word;
        end else if (cmd.fetch_sum || cmd.fetch_top) begin
            word_reg <= rd_addr;
        end
        if (cmd.save_top) begin
            sum_sel_reg <= top_low[SUM_ADDR_W-1:0];
        end
        if (cmd.res_load) begin
            result_reg <= result_next;
        end
    end

    assign status.clr_done  = &clr_cnt_reg;
    assign status.own_hit   = |own_bits;
    assign status.last_word = &word_reg;
    assign status.sum_hit   = |sum_bits;
    assign status.top_hit   = |top_bits;
    assign result           = result_reg;

endmodule

// ===== sv/ordered_set_successor_search_core.sv =====
// top level of the ordered set successor search core
// ordered set of 16-bit keys held as a three-level bitmap: 1024 leaf words of
// 64 bits in a single-port-style memory, 16 summary words and a 16-bit top word
// in flip-flops. each transaction on s_ carries an opcode and a key and yields
// exactly one transaction on m_: insert (result zero), find-next (smallest
// member at or above the key, 65536 when there is none) or lookup (present
// flag). one item is worked on at a time; the leaf memory read with its
// registered output sets the pace. the idle state accepts an item and reads
// its key's leaf word; insert then writes the updated word and lookup tests
// the key's bit, each loading the result. find-next loads it at once when the
// key's own leaf word answers, reads the later word found by the summary level
// and then loads it, or else first picks a summary word from the top level and
// reads through it; a reserved opcode loads its zero result in the idle state.
// a result then waits in the reply state until the output register is free.
// the core is ready for the next item in the cycle after the result enters the
// output register, even while m_ready is low.
// after reset the leaf memory is cleared one word per cycle, so s_ready stays
// low until every word is cleared.
`include "ordered_set_successor_search_core_assert.svh"

module ordered_set_successor_search_core
    import oss_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  in_item_t  s_data,
    output logic      m_valid,
    input  logic      m_ready,
    output out_item_t m_data
);

    dp_cmd_t    cmd;
    dp_status_t status;
    out_item_t  result;
    logic       out_free;
    logic       out_load;

    // output register: frees the controller while a result waits for m_ready
    logic      m_valid_reg;
    out_item_t m_data_reg;

    assign out_free = !m_valid_reg || m_ready;

    oss_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .opcode   (s_data.opcode),
        .out_free (out_free),
        .status   (status),
        .s_ready  (s_ready),
        .out_load (out_load),
        .cmd      (cmd)
    );

    oss_dp u_dp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cmd      (cmd),
        .in_item  (s_data),
        .status   (status),
        .result   (result)
    );

    // valid flag of the output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    // result payload, loaded only when the slot is free or draining
    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_data_reg <= result;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // first cycle out of reset starts the clearing pass, no transaction taken
    `OSS_ASSERT(a_no_accept_after_reset, !$past(aresetn) |-> !s_ready, "input taken during clear")
    // one item at a time: accepting a transaction closes the input side
    `OSS_ASSERT(a_busy_after_accept, s_valid && s_ready |=> !s_ready, "second item taken while busy")
    // a result carries at most one of answer and present, answer within range
    `OSS_ASSERT(a_result_shape,
        m_valid |-> !(m_data.present && m_data.answer != '0) &&
                    (!m_data.answer[KEY_BITS] || m_data.answer[KEY_BITS-1:0] == '0),
        "malformed result")

endmodule

// ===== tb/sv/testbench.sv =====
// self-checking testbench of the ordered set successor search core
`timescale 1ns / 100ps

module testbench;
    import oss_pkg::*;

    // generous cycle budget: leaf clear after reset, about 650 transactions
    // at heavy idling on either side, one long output hold
    localparam int CYCLE_LIMIT = 400000;
    // settle time after the last result
    localparam int TAIL_CYCLES = 16;
    // length of the long output hold that fills the core and stalls s_ready
    localparam int HOLD_LENGTH = 300;
    // find-next answer when no member lies at or above the key
    localparam logic [ANS_W-1:0] NO_MEMBER = ANS_W'(1) << KEY_BITS;

    // one accepted input transaction and the result it must produce
    typedef struct packed {
        in_item_t  cause;
        out_item_t want;
    } awaited_t;

    logic      aclk    = 1'b0;
    logic      aresetn = 1'b0;
    logic      s_valid = 1'b0;
    logic      s_ready;
    in_item_t  s_data  = '0;
    logic      m_valid;
    logic      m_ready = 1'b0;
    out_item_t m_data;

    // shadow copy of the set: leaf bits per key, one summary bit per non-empty
    // leaf word, one top bit per non-empty summary word
    logic [WORD_W-1:0]    leaf_words [LEAF_DEPTH];
    logic [WORD_W-1:0]    sum_words  [SUM_DEPTH];
    logic [SUM_DEPTH-1:0] top_word;

    awaited_t                awaited_results [$];
    logic [KEY_BITS-1:0]     inserted_keys   [$];

    int send_idle_pct   = 0;
    int recv_idle_pct   = 0;
    int hold_cycles     = 0;
    int cycle_count     = 0;
    int checked_count   = 0;
    int mismatch_count  = 0;
    int op_count [4]    = '{0, 0, 0, 0};

    ordered_set_successor_search_core dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // ------------------------------------------------------------------
    // predictor of the set
    // ------------------------------------------------------------------

    task automatic clear_set_model();
        for (int i = 0; i < LEAF_DEPTH; i++) begin
            leaf_words[i] = '0;
        end
        for (int i = 0; i < SUM_DEPTH; i++) begin
            sum_words[i] = '0;
        end
        top_word = '0;
    endtask

    // position of the least significant one; caller guarantees a non-zero word
    function automatic int lowest_one(input logic [WORD_W-1:0] bits);
        for (int i = 0; i < WORD_W; i++) begin
            if (bits[i]) begin
                return i;
            end
        end
        return 0;
    endfunction

    // smallest member at or above key, NO_MEMBER when there is none
    function automatic logic [ANS_W-1:0] successor_of(input logic [KEY_BITS-1:0] key);
        logic [WORD_W-1:0] bits;
        int                word_idx;
        int                first_word;
        int                leaf_idx;
        word_idx = int'(key[KEY_BITS-1:WORD_BITS]);
        // own leaf word, masked below the key
        bits = leaf_words[word_idx] & ({WORD_W{1'b1}} << key[WORD_BITS-1:0]);
        if (bits != '0) begin
            return ANS_W'(word_idx * WORD_W + lowest_one(bits));
        end
        // later leaf words, skipping empty summary words through the top bits
        first_word = word_idx + 1;
        for (int s = first_word / WORD_W; s < SUM_DEPTH; s++) begin
            if (top_word[s]) begin
                bits = sum_words[s];
                if (s == first_word / WORD_W) begin
                    bits &= {WORD_W{1'b1}} << (first_word % WORD_W);
                end
                if (bits != '0) begin
                    leaf_idx = s * WORD_W + lowest_one(bits);
                    return ANS_W'(leaf_idx * WORD_W + lowest_one(leaf_words[leaf_idx]));
                end
            end
        end
        return NO_MEMBER;
    endfunction

    // applies one operation to the shadow set and returns its result
    function automatic out_item_t apply_op(input in_item_t item);
        out_item_t                res;
        logic [LEAF_ADDR_W-1:0]   word_idx;
        res      = '0;
        word_idx = item.key[KEY_BITS-1:WORD_BITS];
        case (item.opcode)
            OP_INSERT: begin
                leaf_words[word_idx][item.key[WORD_BITS-1:0]] = 1'b1;
                sum_words[word_idx[LEAF_ADDR_W-1:WORD_BITS]][word_idx[WORD_BITS-1:0]] = 1'b1;
                top_word[word_idx[LEAF_ADDR_W-1:WORD_BITS]] = 1'b1;
                inserted_keys = {inserted_keys, item.key};
            end
            OP_NEXT: begin
                res.answer = successor_of(item.key);
            end
            OP_LOOKUP: begin
                res.present = leaf_words[word_idx][item.key[WORD_BITS-1:0]];
            end
            default: begin
                // reserved opcode: set untouched, all-zero result
            end
        endcase
        return res;
    endfunction

    // ------------------------------------------------------------------
    // result side
    // ------------------------------------------------------------------

    // m_ready changes on the falling edge: either a long hold-off counted
    // here, or random stalls at the current receiver idle rate
    always @(negedge aclk) begin
        if (hold_cycles > 0) begin
            m_ready     = 1'b0;
            hold_cycles = hold_cycles - 1;
        end else begin
            m_ready = ($urandom_range(99) >= recv_idle_pct);
        end
    end

    task automatic note_mismatch(input string what);
        mismatch_count++;
        if (mismatch_count <= 10) begin
            $display("[%0t] mismatch: %s", $realtime, what);
        end
    endtask

    // every result transaction is compared with the oldest waiting expectation
    always @(posedge aclk) begin
        awaited_t head;
        if (aresetn && m_valid && m_ready) begin
            if (awaited_results.size() == 0) begin
                note_mismatch($sformatf("unexpected result answer=%0d present=%0b",
                                        m_data.answer, m_data.present));
            end else begin
                head = awaited_results.pop_front();
                checked_count++;
                if (m_data.answer !== head.want.answer ||
                    m_data.present !== head.want.present) begin
                    note_mismatch($sformatf(
                        "%s key=0x%04h: expected answer=%0d present=%0b, got answer=%0d present=%0b",
                        head.cause.opcode.name(), head.cause.key,
                        head.want.answer, head.want.present,
                        m_data.answer, m_data.present));
                end
            end
        end
    end

    // hard stop if the core hangs or results go missing
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, awaited_results.size());
            $display("Regression FAIL");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // input side
    // ------------------------------------------------------------------

    // sends one transaction; entered and left at a falling edge, s_valid stays
    // up with a stable payload until the handshake completes
    task automatic send_op(input opcode_t op, input logic [KEY_BITS-1:0] key);
        in_item_t item;
        awaited_t entry;
        item.opcode = op;
        item.key    = key;
        while ($urandom_range(99) < send_idle_pct) begin
            @(negedge aclk);
        end
        s_data  = item;
        s_valid = 1'b1;
        @(posedge aclk);
        while (!s_ready) begin
            @(posedge aclk);
        end
        // the core works on one item at a time, so predicting at acceptance
        // keeps the shadow set in step with the core
        entry.cause = item;
        entry.want  = apply_op(item);
        awaited_results = {awaited_results, entry};
        op_count[int'(op)]++;
        @(negedge aclk);
        s_valid = 1'b0;
    endtask

    // blocks until every expected result has come back
    task automatic wait_drained();
        while (awaited_results.size() != 0) begin
            @(posedge aclk);
        end
        @(negedge aclk);
    endtask

    // keys biased toward members, a few dense clusters and the extremes,
    // so lookups hit and find-next walks every level of the bitmap
    function automatic logic [KEY_BITS-1:0] pick_key();
        int r;
        r = $urandom_range(99);
        if (r < 30 && inserted_keys.size() != 0) begin
            return inserted_keys[$urandom_range(inserted_keys.size() - 1)]
                   + KEY_BITS'($urandom_range(72)) - KEY_BITS'(4);
        end else if (r < 55) begin
            case ($urandom_range(3))
                0:       return 16'h0200 + KEY_BITS'($urandom_range(511));
                1:       return 16'h5000 + KEY_BITS'($urandom_range(511));
                2:       return 16'hA3C0 + KEY_BITS'($urandom_range(511));
                default: return 16'hFE00 + KEY_BITS'($urandom_range(511));
            endcase
        end else if (r < 62) begin
            return $urandom_range(1) ? 16'hFFFF - KEY_BITS'($urandom_range(3))
                                     : KEY_BITS'($urandom_range(3));
        end
        return KEY_BITS'($urandom);
    endfunction

    function automatic opcode_t pick_op();
        int r;
        r = $urandom_range(99);
        if (r < 30) begin
            return OP_INSERT;
        end else if (r < 65) begin
            return OP_NEXT;
        end else if (r < 95) begin
            return OP_LOOKUP;
        end
        return OP_RSVD;
    endfunction

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------

    // empty set, extreme keys, duplicates, reserved opcode and each level
    // of the successor search: own word, later word, later summary word
    task automatic test_directed_edges();
        send_op(OP_NEXT,   16'h0000);   // empty set, no member
        send_op(OP_LOOKUP, 16'h0000);
        send_op(OP_NEXT,   16'hFFFF);
        send_op(OP_RSVD,   16'hFFFF);   // reserved opcode gives zeros
        send_op(OP_INSERT, 16'hFFFF);
        send_op(OP_INSERT, 16'hFFFF);   // duplicate insert
        send_op(OP_LOOKUP, 16'hFFFF);
        send_op(OP_NEXT,   16'h0000);   // answer found through the top level
        send_op(OP_INSERT, 16'h0000);
        send_op(OP_NEXT,   16'h0000);   // own leaf word, exact hit
        send_op(OP_NEXT,   16'h0001);
        send_op(OP_INSERT, 16'h0045);
        send_op(OP_NEXT,   16'h0001);   // later leaf word, same summary word
        send_op(OP_INSERT, 16'h1234);
        send_op(OP_NEXT,   16'h0046);   // later summary word
        send_op(OP_NEXT,   16'h1235);
        send_op(OP_RSVD,   16'h1234);   // reserved opcode leaves the set alone
        send_op(OP_LOOKUP, 16'h1234);
        send_op(OP_LOOKUP, 16'h1233);
        send_op(OP_NEXT,   16'hFFFF);   // last key of the universe
        send_op(OP_INSERT, 16'h003F);
        send_op(OP_NEXT,   16'h0001);   // top bit of the own leaf word
        send_op(OP_LOOKUP, 16'hAAAA);
        send_op(OP_LOOKUP, 16'h5555);
        wait_drained();
    endtask

    // random operations at the given idle rates; every so often the sender
    // pauses until all results are back
    task automatic test_random_traffic(input int count, input int send_pct,
                                       input int recv_pct);
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        for (int i = 0; i < count; i++) begin
            send_op(pick_op(), pick_key());
            if (i % 50 == 49) begin
                wait_drained();
            end
        end
        wait_drained();
    endtask

    // receiver holds off for a long stretch while the sender keeps offering,
    // so the core fills up and drops s_ready
    task automatic test_output_hold();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_cycles   = HOLD_LENGTH;
        for (int i = 0; i < 12; i++) begin
            send_op(pick_op(), pick_key());
        end
        wait_drained();
    endtask

    // short bursts, each followed by a full drain before the next one
    task automatic test_sender_pause();
        send_idle_pct = 0;
        recv_idle_pct = 30;
        for (int b = 0; b < 4; b++) begin
            for (int i = 0; i < 5; i++) begin
                send_op(pick_op(), pick_key());
            end
            wait_drained();
        end
    endtask

    initial begin
        clear_set_model();
        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // s_ready stays low during the leaf clear, send_op just waits for it
        test_directed_edges();
        test_random_traffic(200, 8, 87);
        test_output_hold();
        test_random_traffic(200, 87, 8);
        test_sender_pause();
        test_random_traffic(200, 0, 0);

        wait_drained();
        repeat (TAIL_CYCLES) @(posedge aclk);

        $display("covered %0d transactions: %0d insert, %0d find-next, %0d lookup, %0d reserved",
                 op_count[int'(OP_INSERT)] + op_count[int'(OP_NEXT)] +
                 op_count[int'(OP_LOOKUP)] + op_count[int'(OP_RSVD)],
                 op_count[int'(OP_INSERT)], op_count[int'(OP_NEXT)],
                 op_count[int'(OP_LOOKUP)], op_count[int'(OP_RSVD)]);
        $display("%0d results checked under both idle mixes, a %0d-cycle output hold, %0d mismatches",
                 checked_count, HOLD_LENGTH, mismatch_count);
        if (mismatch_count == 0 && awaited_results.size() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+sv
sv/oss_pkg.sv
sv/oss_ctrl.sv
sv/oss_dp.sv
sv/ordered_set_successor_search_core.sv
tb/sv/testbench.sv
